/* src/nfa_pkg.sv */
// Shared types, constants and helpers for the NFA word acceptor.
// No dependencies; compiled first.
package nfa_pkg;

    localparam int NUM_STATES_DEF      = 16;
    localparam int MAX_TRANSITIONS_DEF = 64;

    localparam int STATE_W  = 4;
    localparam int SYMBOL_W = 8;
    localparam int SET_W    = 16;
    localparam int CFG_W    = 16;

    typedef logic [STATE_W-1:0]  state_idx_t;
    typedef logic [SYMBOL_W-1:0] symbol_t;
    typedef logic [SET_W-1:0]    state_set_t;
    typedef logic [CFG_W-1:0]    cfg_data_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_FEED,
        CMD_END
    } command_t;

    typedef enum logic [0:0] {
        CFG_START_STATE,
        CFG_ACCEPT_MASK
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fsm_state_t;

    // Table entry, packed as from(4) to(4) symbol(8)
    typedef struct packed {
        state_idx_t from_state;
        state_idx_t to_state;
        symbol_t    symbol;
    } tbl_entry_t;

    typedef struct packed {
        logic       clear;
        logic       append;
        logic       scan;
        tbl_entry_t entry;
        symbol_t    symbol;
        state_set_t cur;
    } tbl_req_t;

    typedef struct packed {
        logic       full;
        logic       done;
        state_set_t next_set;
    } tbl_rsp_t;

    // Bits of the live set that name real states
    function automatic state_set_t state_mask(input int n);
        state_set_t m;
        for (int i = 0; i < SET_W; i++)
        begin
            m[i] = (i < n);
        end
        return m;
    endfunction

endpackage

/* src/nfa_item_if.sv */
// Input item channel: valid/ready plus command payload.
// Depends on nfa_pkg.
interface nfa_item_if;
    logic                 valid;
    logic                 ready;
    nfa_pkg::command_t    command;
    nfa_pkg::state_idx_t  from_state;
    nfa_pkg::state_idx_t  to_state;
    nfa_pkg::symbol_t     symbol;

    modport source (output valid, command, from_state, to_state, symbol, input ready);
    modport sink   (input valid, command, from_state, to_state, symbol, output ready);
endinterface

/* src/nfa_result_if.sv */
// Result channel: valid/ready plus status, acceptance and live set.
// Depends on nfa_pkg.
interface nfa_result_if;
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic                 accepted;
    nfa_pkg::state_set_t  live_states;

    modport source (output valid, status, accepted, live_states, input ready);
    modport sink   (input valid, status, accepted, live_states, output ready);
endinterface

/* src/nfa_cfg_if.sv */
// Configuration write channel: valid/ready, register index and data.
// Depends on nfa_pkg.
interface nfa_cfg_if;
    logic                 valid;
    logic                 ready;
    nfa_pkg::cfg_index_t  index;
    nfa_pkg::cfg_data_t   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/nfa_table.sv */
// Transition table memory with its fill count and the single-comparator scan.
// Depends on nfa_pkg.
module nfa_table #(
    parameter int MAX_TRANSITIONS = nfa_pkg::MAX_TRANSITIONS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nfa_pkg::tbl_req_t req,
    output nfa_pkg::tbl_rsp_t rsp
);

    localparam int CNT_W  = $clog2(MAX_TRANSITIONS + 1);
    localparam int ADDR_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;

    nfa_pkg::tbl_entry_t mem [MAX_TRANSITIONS];

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                busy_reg, busy_next;
    logic                rd_valid_reg, rd_valid_next;
    nfa_pkg::tbl_entry_t rd_data_reg;
    nfa_pkg::symbol_t    sym_reg;
    nfa_pkg::state_set_t cur_reg;
    nfa_pkg::state_set_t acc_reg, acc_next;

    logic full;
    logic issue;
    logic hit;
    logic done;

    assign full  = (count_reg == CNT_W'(MAX_TRANSITIONS));
    assign issue = busy_reg && (idx_reg < count_reg);
    assign done  = busy_reg && !issue && !rd_valid_reg;
    assign hit   = rd_valid_reg && (rd_data_reg.symbol == sym_reg)
                   && cur_reg[rd_data_reg.from_state];

    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        busy_next     = busy_reg;
        rd_valid_next = issue;
        acc_next      = acc_reg;

        if (req.clear)
        begin
            count_next = '0;
        end
        else if (req.append && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (req.scan)
        begin
            busy_next     = 1'b1;
            idx_next      = '0;
            rd_valid_next = 1'b0;
            acc_next      = '0;
        end
        else
        begin
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (hit)
            begin
                acc_next = acc_reg | (nfa_pkg::state_set_t'(1) << rd_data_reg.to_state);
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            busy_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            busy_reg     <= busy_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Scan operands and accumulator
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (req.scan)
        begin
            sym_reg <= req.symbol;
            cur_reg <= req.cur;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.append && !full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= req.entry;
        end
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    assign rsp.full     = full;
    assign rsp.done     = done;
    assign rsp.next_set = acc_reg;

endmodule

/* src/nfa_word_acceptor.sv */
// NFA word acceptor top level: control sequencer, live set, config and result register.
// Depends on nfa_pkg, nfa_item_if, nfa_result_if, nfa_cfg_if and nfa_table.
//
// Usage:
//   item   - command transfers: clear table, append transition, feed symbol,
//            end of word. Every transfer yields exactly one result transfer.
//   result - status (append dropped, table full), accepted (end of word only)
//            and the live state set after the item.
//   cfg    - register writes, always ready: index 0 start_state, 1 accept_mask.
//            Write only while the block is idle.
// Timing:
//   clear, append, end of word: result valid the cycle after the transfer.
//   feed symbol: the table is scanned one entry per cycle through one
//   comparator on the table memory's single read port, over all stored
//   transitions (at most MAX_TRANSITIONS); the result is loaded from the FINISH
//   state once the result register is free. item.ready is low during the scan.
// Reset: table empty, live set empty, no word started, config registers zero.
//   No clearing pass; the table memory needs none.
// Stall: the result register holds until taken; a new item is accepted only
//   in a cycle where no scan is pending and the result register is empty or being drained.
module nfa_word_acceptor #(
    parameter int NUM_STATES      = nfa_pkg::NUM_STATES_DEF,
    parameter int MAX_TRANSITIONS = nfa_pkg::MAX_TRANSITIONS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    nfa_item_if.sink      item,
    nfa_result_if.source  result,
    nfa_cfg_if.sink       cfg
);

    // States at or above NUM_STATES never hold a live bit
    localparam nfa_pkg::state_set_t STATE_MASK = nfa_pkg::state_mask(NUM_STATES);

    nfa_pkg::fsm_state_t state_reg, state_next;

    nfa_pkg::state_idx_t start_state_reg;
    nfa_pkg::state_set_t accept_mask_reg;
    nfa_pkg::state_set_t live_reg;
    logic                in_word_reg;

    logic                out_valid_reg;
    logic                out_status_reg;
    logic                out_accepted_reg;
    nfa_pkg::state_set_t out_live_reg;

    nfa_pkg::tbl_req_t   req;
    nfa_pkg::tbl_rsp_t   rsp;

    logic                out_free;
    logic                item_ready;
    logic                item_fire;
    logic                load_now;
    logic                load_finish;
    nfa_pkg::state_set_t start_set;
    nfa_pkg::state_set_t base_set;
    logic                accept_hit;

    assign out_free  = !out_valid_reg || result.ready;
    assign item_fire = item.valid && item_ready;

    // Set a word starts from; the start state counts only if it exists
    assign start_set  = STATE_MASK & (nfa_pkg::state_set_t'(1) << start_state_reg);
    assign base_set   = in_word_reg ? live_reg : start_set;
    assign accept_hit = |(base_set & accept_mask_reg);

    nfa_table #(
        .MAX_TRANSITIONS (MAX_TRANSITIONS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfa_pkg::ST_IDLE:
            begin
                if (item_fire && item.command == nfa_pkg::CMD_FEED)
                begin
                    state_next = nfa_pkg::ST_SCAN;
                end
            end
            nfa_pkg::ST_SCAN:
            begin
                if (rsp.done)
                begin
                    state_next = nfa_pkg::ST_FINISH;
                end
            end
            nfa_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = nfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        item_ready  = 1'b0;
        load_finish = 1'b0;
        unique case (state_reg)
            nfa_pkg::ST_IDLE:   item_ready  = out_free;
            nfa_pkg::ST_SCAN:   item_ready  = 1'b0;
            nfa_pkg::ST_FINISH: load_finish = out_free;
            default:            item_ready  = 1'b0;
        endcase

        load_now = item_fire && (item.command != nfa_pkg::CMD_FEED);

        req.clear            = item_fire && (item.command == nfa_pkg::CMD_CLEAR);
        req.append           = item_fire && (item.command == nfa_pkg::CMD_APPEND);
        req.scan             = item_fire && (item.command == nfa_pkg::CMD_FEED);
        req.entry.from_state = item.from_state;
        req.entry.to_state   = item.to_state;
        req.entry.symbol     = item.symbol;
        req.symbol           = item.symbol;
        req.cur              = base_set;
    end

    assign item.ready = item_ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nfa_pkg::ST_IDLE;
            start_state_reg <= '0;
            accept_mask_reg <= '0;
            live_reg        <= '0;
            in_word_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    nfa_pkg::CFG_START_STATE: start_state_reg <= cfg.data[nfa_pkg::STATE_W-1:0];
                    nfa_pkg::CFG_ACCEPT_MASK: accept_mask_reg <= cfg.data;
                    default:                  accept_mask_reg <= accept_mask_reg;
                endcase
            end

            // Scan result lands once the table walk is over
            if (state_reg == nfa_pkg::ST_SCAN && rsp.done)
            begin
                live_reg <= rsp.next_set & STATE_MASK;
            end
            else if (item_fire && item.command == nfa_pkg::CMD_END)
            begin
                live_reg <= base_set;
            end

            if (item_fire && item.command == nfa_pkg::CMD_FEED)
            begin
                in_word_reg <= 1'b1;
            end
            else if (item_fire && item.command == nfa_pkg::CMD_END)
            begin
                in_word_reg <= 1'b0;
            end

            if (load_now || load_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_now)
        begin
            out_status_reg   <= (item.command == nfa_pkg::CMD_APPEND) && rsp.full;
            out_accepted_reg <= (item.command == nfa_pkg::CMD_END) && accept_hit;
            out_live_reg     <= (item.command == nfa_pkg::CMD_END) ? base_set : live_reg;
        end
        else if (load_finish)
        begin
            out_status_reg   <= 1'b0;
            out_accepted_reg <= 1'b0;
            out_live_reg     <= live_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.accepted    = out_accepted_reg;
    assign result.live_states = out_live_reg;

endmodule
